[rtl/core/gb3_pkg.sv]
// shared constants for the 3x3 gaussian blur block
package gb3_pkg;

  // line store depth default
  localparam int MAX_WIDTH_DEF = 1024;

  // field widths
  localparam int PIX_W     = 8;
  localparam int ROW_W     = 16;
  localparam int OUT_COL_W = 10;
  localparam int CFG_WID_W = 11;
  localparam int CFG_HGT_W = 16;
  localparam int SUM_W     = PIX_W + 4;

  // stream and register port widths
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_FIELD_W = PIX_W + ROW_W + OUT_COL_W;
  localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;
  localparam int APB_DATA_W  = 32;
  localparam int APB_ADDR_W  = 3;

  // register reset values
  localparam logic [CFG_WID_W-1:0] WIDTH_RESET  = 11'd640;
  localparam logic [CFG_HGT_W-1:0] HEIGHT_RESET = 16'd480;

  // register select, taken from address bit 2
  localparam logic REG_IMAGE_WIDTH  = 1'b0;
  localparam logic REG_IMAGE_HEIGHT = 1'b1;

  // results held per input item
  localparam int MAX_RES = 3;

endpackage

[rtl/core/gaussian_blur_3x3.sv]
// 3x3 gaussian blur (1 2 1 / 2 4 2 / 1 2 1) over a raster pixel stream
//
// Usage: pixels enter in raster order on the s_axis channel, one 8-bit pixel
// per item. Results leave on m_axis, each carrying the pixel value, its row
// and its column; tlast marks the final result caused by one input item.
// Row r-1 is produced while row r arrives; the first and last rows and
// columns are passed through unchanged, the last row as soon as it arrives.
// The first row is copied straight through; the second row gives no result.
// Frame size is set over the APB port (width at 0x0, height at 0x4); any
// write restarts the frame at row 0, column 0. Write only while idle.
// A result of an item passes the input register, then the result register,
// before it is shown on m_axis. Throughput: one input item per cycle while
// m_axis is ready and each item causes at most one result; an item causing
// two or three results holds the input while they leave through the single
// result port, one result per cycle while m_axis is ready. The line stores
// are two one-write one-read memories of MAX_WIDTH pixels.
// Reset clears the counters, pipeline and registers (640 x 480); the line
// stores keep their contents. A stalled m_axis holds its result and, once
// the input register is full, drops s_axis_tready.
module gaussian_blur_3x3 #(
  parameter int MAX_WIDTH = gb3_pkg::MAX_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  // fields from bit 0: pixel_in[7:0]
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [gb3_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  // fields from bit 0: pixel_out[7:0], out_row[23:8], out_col[33:24], zero pad
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [gb3_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  output logic                             m_axis_tlast,
  // configuration port
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [gb3_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [gb3_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [gb3_pkg::APB_DATA_W-1:0]   prdata,
  output logic                             pready
);

  localparam int CW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int PW    = gb3_pkg::PIX_W;
  localparam int RW    = gb3_pkg::ROW_W;
  localparam int OCW   = gb3_pkg::OUT_COL_W;
  localparam int SW    = gb3_pkg::SUM_W;
  localparam int NR    = gb3_pkg::MAX_RES;
  localparam int DW    = gb3_pkg::APB_DATA_W;
  localparam int PAD_W = gb3_pkg::OUT_TDATA_W - gb3_pkg::OUT_FIELD_W;

  // configuration registers
  logic [gb3_pkg::CFG_WID_W-1:0] image_width;
  logic [gb3_pkg::CFG_HGT_W-1:0] image_height;
  logic                          cfg_wr;

  // position counters
  logic [CW-1:0] col_count;
  logic [RW-1:0] row_count;
  logic [CW-1:0] w_last;
  logic [RW-1:0] h_last;
  logic [CW-1:0] acc_col;
  logic [RW-1:0] acc_row;

  // input register stage
  logic          s1_valid;
  logic [PW-1:0] s1_pix;
  logic [CW-1:0] s1_col;
  logic [RW-1:0] s1_row;
  logic [PW-1:0] top_q;
  logic [PW-1:0] mid_q;

  // line stores and window
  logic [PW-1:0] older_mem [MAX_WIDTH];
  logic [PW-1:0] prev_mem  [MAX_WIDTH];
  logic [PW-1:0] win [6];

  // result bundle
  logic [PW-1:0]  bun_pix [NR];
  logic [RW-1:0]  bun_row [NR];
  logic [OCW-1:0] bun_col [NR];
  logic [1:0]     bun_cnt;
  logic [1:0]     bun_idx;
  logic [PW-1:0]  bun_pix_next [NR];
  logic [RW-1:0]  bun_row_next [NR];
  logic [OCW-1:0] bun_col_next [NR];
  logic [1:0]     bun_cnt_next;

  logic          in_acc;
  logic          out_acc;
  logic          bun_last;
  logic          bun_free;
  logic          fire;
  logic [SW-1:0] blur_sum;

  // apb access
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;
  assign prdata = (paddr[2] == gb3_pkg::REG_IMAGE_HEIGHT)
                ? DW'(image_height)
                : DW'(image_width);

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= gb3_pkg::WIDTH_RESET;
      image_height <= gb3_pkg::HEIGHT_RESET;
    end else if (cfg_wr) begin
      case (paddr[2])
        gb3_pkg::REG_IMAGE_WIDTH:  image_width  <= pwdata[gb3_pkg::CFG_WID_W-1:0];
        gb3_pkg::REG_IMAGE_HEIGHT: image_height <= pwdata[gb3_pkg::CFG_HGT_W-1:0];
        default: ;
      endcase
    end
  end

  // effective frame size, as last index
  always_comb begin
    if (image_width < 11'd3) begin
      w_last = CW'(2);
    end else if (32'(image_width) > 32'(MAX_WIDTH)) begin
      w_last = CW'(MAX_WIDTH - 1);
    end else begin
      w_last = CW'(image_width - 11'd1);
    end
    h_last = (image_height < 16'd3) ? 16'd2 : (image_height - 16'd1);
  end

  // position of the item being accepted
  assign acc_col = (col_count > w_last) ? '0 : col_count;
  assign acc_row = (row_count > h_last) ? '0 : row_count;

  // handshakes
  assign bun_last      = (bun_idx == (bun_cnt - 2'd1));
  assign out_acc       = m_axis_tvalid & m_axis_tready;
  assign bun_free      = (bun_cnt == 2'd0) | (m_axis_tready & bun_last);
  assign fire          = s1_valid & bun_free;
  assign s_axis_tready = ~s1_valid | fire;
  assign in_acc        = s_axis_tvalid & s_axis_tready;

  // counters advance per accepted item, restart on any register write
  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
    end else if (cfg_wr) begin
      col_count <= '0;
      row_count <= '0;
    end else if (in_acc) begin
      if (acc_col == w_last) begin
        col_count <= '0;
        row_count <= (acc_row == h_last) ? '0 : (acc_row + 16'd1);
      end else begin
        col_count <= acc_col + CW'(1);
        row_count <= acc_row;
      end
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_acc) begin
      s1_valid <= 1'b1;
    end else if (fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_pix <= s_axis_tdata[PW-1:0];
      s1_col <= acc_col;
      s1_row <= acc_row;
    end
  end

  // line store reads on accept, writes when the item leaves the input register
  always_ff @(posedge clk) begin
    if (in_acc) begin
      top_q <= older_mem[acc_col];
      mid_q <= prev_mem[acc_col];
    end
    if (fire) begin
      older_mem[s1_col] <= mid_q;
      prev_mem[s1_col]  <= s1_pix;
    end
  end

  // window shift
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 6; i++) begin
        win[i] <= '0;
      end
    end else if (fire) begin
      win[3] <= win[0];
      win[4] <= win[1];
      win[5] <= win[2];
      win[0] <= top_q;
      win[1] <= mid_q;
      win[2] <= s1_pix;
    end
  end

  // weighted 3x3 sum
  assign blur_sum = SW'(win[3]) + (SW'(win[4]) << 1) + SW'(win[5])
                  + (SW'(win[0]) << 1) + (SW'(win[1]) << 2)
                  + (SW'(win[2]) << 1)
                  + SW'(top_q) + (SW'(mid_q) << 1) + SW'(s1_pix);

  // results caused by the item in the input register
  always_comb begin
    logic [1:0] k;
    k = 2'd0;
    for (int i = 0; i < NR; i++) begin
      bun_pix_next[i] = '0;
      bun_row_next[i] = '0;
      bun_col_next[i] = '0;
    end
    if (s1_row == '0) begin
      // first row copied through
      bun_pix_next[k] = s1_pix;
      bun_row_next[k] = '0;
      bun_col_next[k] = OCW'(s1_col);
      k = k + 2'd1;
    end else if (s1_row >= 16'd2) begin
      if (s1_col == '0) begin
        // left border of the row above
        bun_pix_next[k] = mid_q;
        bun_row_next[k] = s1_row - 16'd1;
        bun_col_next[k] = '0;
        k = k + 2'd1;
      end else if (s1_col >= CW'(2)) begin
        // interior pixel of the row above
        bun_pix_next[k] = blur_sum[SW-1:4];
        bun_row_next[k] = s1_row - 16'd1;
        bun_col_next[k] = OCW'(s1_col - CW'(1));
        k = k + 2'd1;
        if (s1_col == w_last) begin
          // right border of the row above
          bun_pix_next[k] = mid_q;
          bun_row_next[k] = s1_row - 16'd1;
          bun_col_next[k] = OCW'(s1_col);
          k = k + 2'd1;
        end
      end
      if (s1_row == h_last) begin
        // last row copied through
        bun_pix_next[k] = s1_pix;
        bun_row_next[k] = s1_row;
        bun_col_next[k] = OCW'(s1_col);
        k = k + 2'd1;
      end
    end
    bun_cnt_next = k;
  end

  // result bundle control
  always_ff @(posedge clk) begin
    if (rst) begin
      bun_cnt <= 2'd0;
      bun_idx <= 2'd0;
    end else if (fire) begin
      bun_cnt <= bun_cnt_next;
      bun_idx <= 2'd0;
    end else if (out_acc) begin
      if (bun_last) begin
        bun_cnt <= 2'd0;
        bun_idx <= 2'd0;
      end else begin
        bun_idx <= bun_idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      for (int i = 0; i < NR; i++) begin
        bun_pix[i] <= bun_pix_next[i];
        bun_row[i] <= bun_row_next[i];
        bun_col[i] <= bun_col_next[i];
      end
    end
  end

  // output channel
  assign m_axis_tvalid = (bun_cnt != 2'd0);
  assign m_axis_tlast  = bun_last;
  assign m_axis_tdata  = {{PAD_W{1'b0}}, bun_col[bun_idx], bun_row[bun_idx],
                          bun_pix[bun_idx]};

endmodule
